[rtl/ec_prime_point_add_and_scalar_mul_macros.svh]
// assertion helpers, clocked on aclk with the synchronous active-low reset
`ifndef EC_PRIME_POINT_ADD_AND_SCALAR_MUL_MACROS_SVH
`define EC_PRIME_POINT_ADD_AND_SCALAR_MUL_MACROS_SVH

// same-cycle implication
`define ECPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ecpm_pkg.sv]
package ecpm_pkg;

    // external field widths
    localparam int IN_W       = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    // parameter defaults
    localparam int DEF_FIELD_BITS  = 16;
    localparam int DEF_SCALAR_BITS = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_A = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIME   = 1'b1;

    // register reset values and limits
    localparam int RESET_CURVE_A = 0;
    localparam int RESET_PRIME   = 7;
    localparam int MIN_PRIME     = 3;

endpackage

[rtl/ec_prime_point_add_and_scalar_mul.sv]
// mode 0: five load reductions of width W = max(16, FIELD_BITS) plus one point operation
// one point operation: serial field multiplies and the extended euclid steps of the inverse,
//   all on one serial unit
// mode 1: load plus up to 2*SCALAR_BITS point operations
// throughput: one transaction at a time; s_tready is high only while the sequencer is idle
// reset: synchronous active-low aresetn clears the sequencer, output valid, curve_a=0, p=7
`include "ec_prime_point_add_and_scalar_mul_macros.svh"

module ec_prime_point_add_and_scalar_mul
    import ecpm_pkg::*;
#(
    parameter int FIELD_BITS  = DEF_FIELD_BITS,
    parameter int SCALAR_BITS = DEF_SCALAR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // first_x, first_y, second_x, second_y, scalar
    input  logic                  s_tuser,  // mode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // result_x, result_y
    output logic                  m_tuser   // at_infinity
);

    localparam int F      = FIELD_BITS;
    localparam int FP1    = FIELD_BITS + 1;
    localparam int S      = SCALAR_BITS;
    // width of the serial multiplier operand, covers raw input coordinates too
    localparam int W      = (FIELD_BITS > IN_W) ? FIELD_BITS : IN_W;
    localparam int CNT_W  = $clog2(W + 1);
    localparam int KC_W   = $clog2(SCALAR_BITS + 1);

    // load sequence indexes
    localparam logic [2:0] LD_FX = 3'd0;
    localparam logic [2:0] LD_FY = 3'd1;
    localparam logic [2:0] LD_SX = 3'd2;
    localparam logic [2:0] LD_SY = 3'd3;
    localparam logic [2:0] LD_A  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LD, ST_LDWB, ST_MUL, ST_ADD, ST_SQ1, ST_SQ2, ST_SQ3,
        ST_INV, ST_EUC, ST_DIV, ST_EUCUP, ST_LAM, ST_XR1, ST_XR2, ST_YR,
        ST_ADONE, ST_DONE
    } state_t;

    // which points feed the point operation
    typedef enum logic [1:0] {
        OP_PQ,   // first + second
        OP_DBL,  // accumulator doubled
        OP_RP    // accumulator + first
    } op_t;

    // modular add of two residues
    function automatic logic [F-1:0] addm(input logic [F-1:0] x, input logic [F-1:0] y,
                                          input logic [F-1:0] p);
        logic [F:0] s;
        s = FP1'(x) + FP1'(y);
        if (s >= FP1'(p)) s = s - FP1'(p);
        return s[F-1:0];
    endfunction

    // modular subtract of two residues
    function automatic logic [F-1:0] subm(input logic [F-1:0] x, input logic [F-1:0] y,
                                          input logic [F-1:0] p);
        logic [F:0] s;
        if (x >= y) s = FP1'(x) - FP1'(y);
        else        s = FP1'(x) + FP1'(p) - FP1'(y);
        return s[F-1:0];
    endfunction

    // one msb-first step of a modular multiply: 2*acc + (b ? v : 0) mod p
    function automatic logic [F-1:0] mstep(input logic [F-1:0] acc, input logic b,
                                           input logic [F-1:0] v, input logic [F-1:0] p);
        logic [F:0] d;
        d = {acc, 1'b0};
        if (d >= FP1'(p)) d = d - FP1'(p);
        if (b) d = d + FP1'(v);
        if (d >= FP1'(p)) d = d - FP1'(p);
        return d[F-1:0];
    endfunction

    // configuration
    logic [F-1:0]      curve_a_reg, p_reg;

    // sequencer
    state_t            state_reg, ret_reg;
    op_t               opsel_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [2:0]        ld_reg;
    logic [KC_W-1:0]   kcnt_reg;

    // latched transaction
    logic              mode_reg;
    logic [IN_W-1:0]   fx_reg, fy_reg, sx_reg, sy_reg;
    logic [S-1:0]      k_reg;

    // points, reduced
    logic [F-1:0]      px_reg, py_reg, qx_reg, qy_reg, a_reg;
    logic              pinf_reg, qinf_reg;
    logic [F-1:0]      rx_reg, ry_reg;
    logic              rinf_reg;

    // shared serial unit and working values
    logic [W-1:0]      mu_reg;
    logic [F-1:0]      mv_reg, acc_reg;
    logic [F-1:0]      rem_reg, dsh_reg, r0_reg, r1_reg, t0_reg, t1_reg;
    logic [F-1:0]      num_reg, tmp_reg, m_reg, xn_reg;

    // output register
    logic              m_valid_reg, oinf_reg;
    logic [IN_W-1:0]   ox_reg, oy_reg;

    // operand selection
    logic [F-1:0]      ax, ay, bx, by;
    logic              ainf, binf;
    logic [W-1:0]      ld_val;
    logic              div_q;
    logic [F:0]        div_sh, div_diff;
    logic [F-1:0]      div_rem, step_acc, xr_new;

    always_comb begin
        case (opsel_reg)
            OP_PQ: begin
                ax = px_reg; ay = py_reg; ainf = pinf_reg;
                bx = qx_reg; by = qy_reg; binf = qinf_reg;
            end
            OP_DBL: begin
                ax = rx_reg; ay = ry_reg; ainf = rinf_reg;
                bx = rx_reg; by = ry_reg; binf = rinf_reg;
            end
            default: begin
                ax = rx_reg; ay = ry_reg; ainf = rinf_reg;
                bx = px_reg; by = py_reg; binf = pinf_reg;
            end
        endcase
    end

    // raw values reduced during load
    always_comb begin
        case (ld_reg)
            LD_FX:   ld_val = W'(fx_reg);
            LD_FY:   ld_val = W'(fy_reg);
            LD_SX:   ld_val = W'(sx_reg);
            LD_SY:   ld_val = W'(sy_reg);
            default: ld_val = W'(a_reg);
        endcase
    end

    // restoring division step of euclid; the quotient bit feeds the multiply step
    // so q*t1 mod p builds up alongside the quotient
    always_comb begin
        div_sh   = {rem_reg, dsh_reg[F-1]};
        div_diff = div_sh - FP1'(r1_reg);
        div_q    = (div_sh >= FP1'(r1_reg));
        div_rem  = div_q ? div_diff[F-1:0] : div_sh[F-1:0];
        step_acc = mstep(acc_reg, (state_reg == ST_DIV) ? div_q : mu_reg[W-1],
                         (state_reg == ST_DIV) ? t1_reg : mv_reg, p_reg);
        xr_new   = subm(tmp_reg, bx, p_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = oinf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            curve_a_reg <= F'(RESET_CURVE_A);
            p_reg       <= F'(RESET_PRIME);
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CURVE_A: curve_a_reg <= F'(cfg_wdata);
                    REG_PRIME:   p_reg       <= F'(cfg_wdata);
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg <= s_tuser;
                        fx_reg   <= s_tdata[15:0];
                        fy_reg   <= s_tdata[31:16];
                        sx_reg   <= s_tdata[47:32];
                        sy_reg   <= s_tdata[63:48];
                        k_reg    <= S'(s_tdata[79:64]);
                        pinf_reg <= (s_tdata[31:0] == 32'd0);
                        qinf_reg <= (s_tdata[63:32] == 32'd0);
                        a_reg    <= curve_a_reg;
                        if (p_reg < F'(MIN_PRIME)) begin
                            // degenerate modulus: infinity without work
                            rx_reg    <= '0;
                            ry_reg    <= '0;
                            rinf_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            ld_reg    <= LD_FX;
                            state_reg <= ST_LD;
                        end
                    end
                end
                ST_LD: begin
                    // value mod p as value * 1 mod p
                    mu_reg    <= ld_val;
                    mv_reg    <= F'(1);
                    acc_reg   <= '0;
                    cnt_reg   <= CNT_W'(W);
                    ret_reg   <= ST_LDWB;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    acc_reg <= step_acc;
                    mu_reg  <= mu_reg << 1;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) state_reg <= ret_reg;
                end
                ST_LDWB: begin
                    case (ld_reg)
                        LD_FX:   px_reg <= acc_reg;
                        LD_FY:   py_reg <= acc_reg;
                        LD_SX:   qx_reg <= acc_reg;
                        LD_SY:   qy_reg <= acc_reg;
                        default: a_reg  <= acc_reg;
                    endcase
                    if (ld_reg == LD_A) begin
                        if (mode_reg) begin
                            rx_reg    <= '0;
                            ry_reg    <= '0;
                            rinf_reg  <= 1'b1;
                            opsel_reg <= OP_DBL;
                            kcnt_reg  <= KC_W'(S);
                        end else begin
                            opsel_reg <= OP_PQ;
                        end
                        state_reg <= ST_ADD;
                    end else begin
                        ld_reg    <= ld_reg + 3'd1;
                        state_reg <= ST_LD;
                    end
                end
                ST_ADD: begin
                    if (ainf) begin
                        rx_reg <= bx; ry_reg <= by; rinf_reg <= binf;
                        state_reg <= ST_ADONE;
                    end else if (binf) begin
                        rx_reg <= ax; ry_reg <= ay; rinf_reg <= 1'b0;
                        state_reg <= ST_ADONE;
                    end else if (ax == bx) begin
                        if (ay != by || ay == '0) begin
                            // inverse points or vertical tangent
                            rx_reg <= '0; ry_reg <= '0; rinf_reg <= 1'b1;
                            state_reg <= ST_ADONE;
                        end else begin
                            mu_reg    <= W'(ax);
                            mv_reg    <= ax;
                            acc_reg   <= '0;
                            cnt_reg   <= CNT_W'(W);
                            ret_reg   <= ST_SQ1;
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        num_reg   <= subm(by, ay, p_reg);
                        tmp_reg   <= subm(bx, ax, p_reg);
                        state_reg <= ST_INV;
                    end
                end
                // tangent slope numerator 3*x^2 + a, denominator 2*y
                ST_SQ1: begin
                    tmp_reg   <= acc_reg;
                    num_reg   <= addm(acc_reg, acc_reg, p_reg);
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    num_reg   <= addm(num_reg, tmp_reg, p_reg);
                    state_reg <= ST_SQ3;
                end
                ST_SQ3: begin
                    num_reg   <= addm(num_reg, a_reg, p_reg);
                    tmp_reg   <= addm(ay, ay, p_reg);
                    state_reg <= ST_INV;
                end
                ST_INV: begin
                    if (tmp_reg == '0) begin
                        rx_reg <= '0; ry_reg <= '0; rinf_reg <= 1'b1;
                        state_reg <= ST_ADONE;
                    end else begin
                        r0_reg    <= p_reg;
                        r1_reg    <= tmp_reg;
                        t0_reg    <= '0;
                        t1_reg    <= F'(1);
                        state_reg <= ST_EUC;
                    end
                end
                ST_EUC: begin
                    if (r1_reg == '0) begin
                        if (r0_reg != F'(1)) begin
                            // no inverse, gcd above one
                            rx_reg <= '0; ry_reg <= '0; rinf_reg <= 1'b1;
                            state_reg <= ST_ADONE;
                        end else begin
                            mu_reg    <= W'(num_reg);
                            mv_reg    <= t0_reg;
                            acc_reg   <= '0;
                            cnt_reg   <= CNT_W'(W);
                            ret_reg   <= ST_LAM;
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        dsh_reg   <= r0_reg;
                        rem_reg   <= '0;
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(F);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_rem;
                    dsh_reg <= dsh_reg << 1;
                    acc_reg <= step_acc;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) state_reg <= ST_EUCUP;
                end
                ST_EUCUP: begin
                    // t kept as a residue mod p
                    r0_reg    <= r1_reg;
                    r1_reg    <= rem_reg;
                    t0_reg    <= t1_reg;
                    t1_reg    <= subm(t0_reg, acc_reg, p_reg);
                    state_reg <= ST_EUC;
                end
                ST_LAM: begin
                    m_reg     <= acc_reg;
                    mu_reg    <= W'(acc_reg);
                    mv_reg    <= acc_reg;
                    acc_reg   <= '0;
                    cnt_reg   <= CNT_W'(W);
                    ret_reg   <= ST_XR1;
                    state_reg <= ST_MUL;
                end
                ST_XR1: begin
                    tmp_reg   <= subm(acc_reg, ax, p_reg);
                    state_reg <= ST_XR2;
                end
                ST_XR2: begin
                    xn_reg    <= xr_new;
                    mu_reg    <= W'(m_reg);
                    mv_reg    <= subm(ax, xr_new, p_reg);
                    acc_reg   <= '0;
                    cnt_reg   <= CNT_W'(W);
                    ret_reg   <= ST_YR;
                    state_reg <= ST_MUL;
                end
                ST_YR: begin
                    rx_reg    <= xn_reg;
                    ry_reg    <= subm(acc_reg, ay, p_reg);
                    rinf_reg  <= 1'b0;
                    state_reg <= ST_ADONE;
                end
                ST_ADONE: begin
                    if (!mode_reg) begin
                        state_reg <= ST_DONE;
                    end else if (opsel_reg == OP_DBL && k_reg[S-1]) begin
                        opsel_reg <= OP_RP;
                        state_reg <= ST_ADD;
                    end else begin
                        // next scalar bit, msb first
                        k_reg <= k_reg << 1;
                        if (kcnt_reg == KC_W'(1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            kcnt_reg  <= kcnt_reg - KC_W'(1);
                            opsel_reg <= OP_DBL;
                            state_reg <= ST_ADD;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        ox_reg      <= rinf_reg ? '0 : IN_W'(rx_reg);
                        oy_reg      <= rinf_reg ? '0 : IN_W'(ry_reg);
                        oinf_reg    <= rinf_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ECPM_ASSERT_IMP(a_acc_residue, (state_reg == ST_MUL || state_reg == ST_DIV), (acc_reg < p_reg), "serial accumulator left the residue range")
    `ECPM_ASSERT_IMP(a_div_rem, (state_reg == ST_DIV), (rem_reg < r1_reg && r1_reg != '0), "division remainder not below divisor")
    `ECPM_ASSERT_IMP(a_inf_zero, (m_valid_reg && oinf_reg), (ox_reg == '0 && oy_reg == '0), "infinity result with nonzero coordinates")
    `ECPM_ASSERT_NXT(a_busy_after_accept, (s_tvalid && s_tready), (!s_tready), "sequencer idle right after an accepted transaction")

endmodule
